// ----- src/spi2d_pkg.sv -----
package spi2d_pkg;

   // defaults for the top level parameters
   localparam int COORD_WIDTH_DEF      = 32;
   localparam int SINE_TABLE_DEPTH_DEF = 1024;

   // field widths of the streams
   localparam int FIELD_W   = 32;
   localparam int ANGLE_W   = 16;
   localparam int REQ_DATA_W = 288;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 8;
   localparam int RSP_USER_W = 1;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // sine series constants
   localparam logic [63:0] ONE_Q30     = 64'd1073741824;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] UNIT_Q16    = 64'd65536;
   localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

   // pair kinds
   typedef enum logic [2:0] {
      CMD_CC   = 3'd0,
      CMD_BB   = 3'd1,
      CMD_CB   = 3'd2,
      CMD_COBB = 3'd3,
      CMD_BOBB = 3'd4,
      CMD_OO   = 3'd5
   } cmd_type;

   // cosine and sine in Q1.16
   typedef struct packed {
      logic signed [17:0] cos;
      logic signed [17:0] sin;
   } trig_type;

   // one classified pair as it moves from front to back
   typedef struct packed {
      cmd_type            op;
      logic               bad;
      logic signed [31:0] a_x0;
      logic signed [31:0] a_y0;
      logic signed [31:0] a_x1;
      logic signed [31:0] a_y1;
      logic signed [31:0] b_x0;
      logic signed [31:0] b_y0;
      logic signed [31:0] b_x1;
      logic signed [31:0] b_y1;
      trig_type           t1;
      trig_type           t2;
   } job_type;

   // sine over the quarter wave, Horner series in Q2.30
   function automatic logic [63:0] quarter_sin(input logic [63:0] u);
      logic [63:0] x, x2, t, r;
      x  = (u * HALF_PI_Q30) >> 30;
      x2 = (x * x) >> 30;
      t  = ONE_Q30 - x2 / 64'd110;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
      r  = (((x * t) >> 30) + 64'd8192) >> 14;
      return (r > UNIT_Q16) ? UNIT_Q16 : r;
   endfunction

   // sine of a Q0.32 turn fraction with quadrant symmetry
   function automatic logic signed [17:0] sin_phase(input logic [31:0] phase);
      logic [63:0]        u, v;
      logic signed [17:0] mag;
      u = {34'd0, phase[29:0]};
      if (phase[30]) u = ONE_Q30 - u;
      v   = quarter_sin(u);
      mag = 18'(v);
      return phase[31] ? -mag : mag;
   endfunction

   // floor(idx * 2^32 / depth) by shift and subtract
   function automatic logic [31:0] phase_of(input logic [31:0] idx, input logic [31:0] depth);
      logic [63:0] num, rem, q;
      num = {idx, 32'd0};
      rem = '0;
      q   = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[62:0], num[i]};
         q   = {q[62:0], 1'b0};
         if (rem >= {32'd0, depth}) begin
            rem  = rem - {32'd0, depth};
            q[0] = 1'b1;
         end
      end
      return q[31:0];
   endfunction

   // one entry of the angle table
   function automatic trig_type trig_entry(input logic [31:0] idx, input logic [31:0] depth);
      trig_type    r;
      logic [31:0] ph;
      ph    = phase_of(idx, depth);
      r.sin = sin_phase(ph);
      r.cos = sin_phase(ph + QUARTER_TURN);
      return r;
   endfunction

endpackage

// ----- src/spi2d_front.sv -----
module spi2d_front import spi2d_pkg::*; #(
   parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
   parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  job_valid,
   input  logic                  job_ready,
   output job_type               job
);

   localparam int EW = (COORD_WIDTH < FIELD_W) ? COORD_WIDTH : FIELD_W;
   localparam int IW = $clog2(SINE_TABLE_DEPTH);
   localparam int PW = ANGLE_W + IW + 1;

   function automatic logic signed [31:0] coord(input logic [31:0] raw);
      logic signed [EW-1:0] t;
      t = raw[EW-1:0];
      return 32'(t);
   endfunction

   // angle table, read with a registered port
   trig_type trig_rom [SINE_TABLE_DEPTH];
   for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_rom
      assign trig_rom[g] = trig_entry(32'(g), 32'(SINE_TABLE_DEPTH));
   end

   logic              valid_ff, valid_in;
   job_type           job_ff, job_in;
   trig_type          t1_ff, t2_ff;
   logic              adv;
   logic              cmd_bad;
   logic [ANGLE_W-1:0] a_ang, b_ang, ang1, ang2;
   logic [PW-1:0]     prod1, prod2;
   logic [IW-1:0]     idx1, idx2;

   assign adv        = !valid_ff || job_ready;
   assign req_tready = adv;
   assign valid_in   = req_tvalid;

   // classify the pair and pick the table angles
   always_comb begin
      a_ang   = req_tdata[143:128];
      b_ang   = req_tdata[287:272];
      cmd_bad = !(req_tuser inside {CMD_CC, CMD_BB, CMD_CB, CMD_COBB, CMD_BOBB, CMD_OO});
      ang1    = (req_tuser == CMD_OO) ? a_ang : b_ang;
      ang2    = (req_tuser == CMD_OO) ? ANGLE_W'(b_ang - a_ang) : b_ang;
      prod1   = PW'(ang1) * PW'(SINE_TABLE_DEPTH);
      prod2   = PW'(ang2) * PW'(SINE_TABLE_DEPTH);
      idx1    = prod1[ANGLE_W +: IW];
      idx2    = prod2[ANGLE_W +: IW];
      job_in      = '0;
      job_in.op   = cmd_bad ? CMD_CC : cmd_type'(req_tuser);
      job_in.bad  = cmd_bad;
      job_in.a_x0 = coord(req_tdata[31:0]);
      job_in.a_y0 = coord(req_tdata[63:32]);
      job_in.a_x1 = coord(req_tdata[95:64]);
      job_in.a_y1 = coord(req_tdata[127:96]);
      job_in.b_x0 = coord(req_tdata[175:144]);
      job_in.b_y0 = coord(req_tdata[207:176]);
      job_in.b_x1 = coord(req_tdata[239:208]);
      job_in.b_y1 = coord(req_tdata[271:240]);
   end

   // front register with table reads
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
      if (adv && req_tvalid) begin
         job_ff <= job_in;
         t1_ff  <= trig_rom[idx1];
         t2_ff  <= trig_rom[idx2];
      end
   end

   // merge the table reads into the outgoing job
   always_comb begin
      job    = job_ff;
      job.t1 = t1_ff;
      job.t2 = t2_ff;
   end

   assign job_valid = valid_ff;

endmodule

// ----- src/spi2d_queue.sv -----
module spi2d_queue import spi2d_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  job_type push_data,
   output logic    pop_valid,
   input  logic    pop_ready,
   output job_type pop_data
);

   localparam int QW = $clog2(QUEUE_DEPTH);

   job_type      mem_ff [QUEUE_DEPTH];
   logic [QW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QW:0]   cnt_ff, cnt_in;
   logic          push, pop;

   assign push_ready = (cnt_ff != (QW+1)'(QUEUE_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = mem_ff[rd_ff];

   // pointer and fill count update
   always_comb begin
      wr_in  = push ? QW'(wr_ff + 1'b1) : wr_ff;
      rd_in  = pop ? QW'(rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + (QW+1)'(push) - (QW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

// ----- src/spi2d_back.sv -----
module spi2d_back import spi2d_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  job_valid,
   output logic                  job_ready,
   input  job_type               job,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [RSP_USER_W-1:0] rsp_tuser
);

   localparam int NST = 10;

   typedef struct packed {
      logic signed [32:0] cdx;
      logic signed [32:0] cdy;
      logic signed [32:0] rr;
      logic               bb;
   } side_type;

   function automatic logic signed [31:0] clamp32(input logic signed [31:0] v, lo, hi);
      logic signed [31:0] r;
      r = v;
      if (v < lo) r = lo;
      else if (v > hi) r = hi;
      return r;
   endfunction

   function automatic logic signed [35:0] clamp36(input logic signed [35:0] v, lo, hi);
      logic signed [35:0] r;
      r = v;
      if (v < lo) r = lo;
      else if (v > hi) r = hi;
      return r;
   endfunction

   // round a Q16.16 x Q1.16 sum back to Q16.16, floor after adding half
   function automatic logic signed [35:0] rnd_a(input logic signed [51:0] v);
      logic signed [51:0] t;
      t = v + 52'sd32768;
      return 36'(t >>> 16);
   endfunction

   function automatic logic signed [38:0] rnd_b(input logic signed [54:0] v);
      logic signed [54:0] t;
      t = v + 55'sd32768;
      return 39'(t >>> 16);
   endfunction

   logic [NST-1:0] vld_ff;
   logic           adv;
   job_type        job_ff  [1:9];
   side_type       side_ff [1:9];
   side_type       side_in;

   // stage registers
   logic signed [32:0] ux_ff, uy_ff, ux_in, uy_in;
   logic signed [50:0] m1_ff, m2_ff, m3_ff, m4_ff;
   logic signed [35:0] rx_ff, ry_ff;
   logic signed [35:0] p_ff, q_ff, cx4_ff, cy4_ff, p_in, q_in, cx_in, cy_in;
   logic signed [53:0] pp1_ff, pp2_ff, pp3_ff, pp4_ff;
   logic signed [35:0] cx5_ff, cy5_ff;
   logic signed [39:0] vax_in [4], vay_in [4], vbx_in [4], vby_in [4];
   logic signed [39:0] vax_ff [4], vay_ff [4], vbx_ff [4], vby_ff [4];
   logic signed [39:0] vax7_ff [4], vay7_ff [4], vbx7_ff [4], vby7_ff [4];
   logic signed [34:0] ex_ff, ey_ff, ex_in, ey_in;
   logic signed [57:0] ma_ff [4][4], mb_ff [4][4];
   logic signed [69:0] ex2_ff, ey2_ff;
   logic signed [65:0] r2_ff;
   logic signed [58:0] pa_in [4][4], pb_in [4][4], pa_ff [4][4], pb_ff [4][4];
   logic               chit8_ff, chit9_ff, chit_in;
   logic signed [58:0] amin_in [4], amax_in [4], bmin_in [4], bmax_in [4];
   logic signed [58:0] amin_ff [4], amax_ff [4], bmin_ff [4], bmax_ff [4];
   logic               hit_ff, bad_ff, hit_in, ovl;
   logic signed [31:0] clx, cly;
   logic signed [35:0] hx36, hy36;
   logic signed [54:0] sx_sum [4], sy_sum [4];

   assign adv        = !vld_ff[NST-1] || rsp_tready;
   assign job_ready  = adv;
   assign rsp_tvalid = vld_ff[NST-1];
   assign rsp_tdata  = {(RSP_DATA_W-1)'(0), hit_ff};
   assign rsp_tuser  = bad_ff;

   // stage 1: differences, closest point on a box, box-box overlap
   always_comb begin
      if (job.op == CMD_OO) begin
         ux_in = 33'(job.b_x0) - 33'(job.a_x0);
         uy_in = 33'(job.b_y0) - 33'(job.a_y0);
      end else begin
         ux_in = 33'(job.a_x0) - 33'(job.b_x0);
         uy_in = 33'(job.a_y0) - 33'(job.b_y0);
      end
      clx = clamp32(job.a_x0, job.b_x0, job.b_x1);
      cly = clamp32(job.a_y0, job.b_y0, job.b_y1);
      if (job.op == CMD_CB) begin
         side_in.cdx = 33'(job.a_x0) - 33'(clx);
         side_in.cdy = 33'(job.a_y0) - 33'(cly);
      end else begin
         side_in.cdx = 33'(job.a_x0) - 33'(job.b_x0);
         side_in.cdy = 33'(job.a_y0) - 33'(job.b_y0);
      end
      side_in.rr = (job.op == CMD_CC) ? 33'(job.a_x1) + 33'(job.b_x1) : 33'(job.a_x1);
      side_in.bb = !((job.a_x1 < job.b_x0) || (job.a_x0 > job.b_x1) ||
                     (job.a_y1 < job.b_y0) || (job.a_y0 > job.b_y1));
   end

   // stage 4: clamp into the box frame, pick rotation operands and center
   always_comb begin
      hx36 = 36'(job_ff[3].b_x1);
      hy36 = 36'(job_ff[3].b_y1);
      if (job_ff[3].op == CMD_COBB) begin
         p_in  = clamp36(rx_ff, -hx36, hx36);
         q_in  = clamp36(ry_ff, -hy36, hy36);
         cx_in = '0;
         cy_in = '0;
      end else begin
         p_in  = hx36;
         q_in  = hy36;
         cx_in = (job_ff[3].op == CMD_OO) ? rx_ff : 36'(job_ff[3].b_x0);
         cy_in = (job_ff[3].op == CMD_OO) ? ry_ff : 36'(job_ff[3].b_y0);
      end
   end

   // stage 6: corners of both boxes, circle offset
   always_comb begin
      sx_sum[0] = -55'(pp1_ff) + 55'(pp2_ff);
      sy_sum[0] = -55'(pp3_ff) - 55'(pp4_ff);
      sx_sum[1] =  55'(pp1_ff) - 55'(pp2_ff);
      sy_sum[1] =  55'(pp3_ff) + 55'(pp4_ff);
      sx_sum[2] = -55'(pp1_ff) - 55'(pp2_ff);
      sy_sum[2] = -55'(pp3_ff) + 55'(pp4_ff);
      sx_sum[3] =  55'(pp1_ff) + 55'(pp2_ff);
      sy_sum[3] =  55'(pp3_ff) - 55'(pp4_ff);
      for (int k = 0; k < 4; k++) begin
         vbx_in[k] = 40'(rnd_b(sx_sum[k])) + 40'(cx5_ff);
         vby_in[k] = 40'(rnd_b(sy_sum[k])) + 40'(cy5_ff);
      end
      if (job_ff[5].op == CMD_OO) begin
         vax_in[0] = -40'(job_ff[5].a_x1);
         vay_in[0] = -40'(job_ff[5].a_y1);
         vax_in[1] =  40'(job_ff[5].a_x1);
         vay_in[1] =  40'(job_ff[5].a_y1);
         vax_in[2] = -40'(job_ff[5].a_x1);
         vay_in[2] =  40'(job_ff[5].a_y1);
         vax_in[3] =  40'(job_ff[5].a_x1);
         vay_in[3] = -40'(job_ff[5].a_y1);
      end else begin
         vax_in[0] = 40'(job_ff[5].a_x0);
         vay_in[0] = 40'(job_ff[5].a_y0);
         vax_in[1] = 40'(job_ff[5].a_x1);
         vay_in[1] = 40'(job_ff[5].a_y1);
         vax_in[2] = 40'(job_ff[5].a_x0);
         vay_in[2] = 40'(job_ff[5].a_y1);
         vax_in[3] = 40'(job_ff[5].a_x1);
         vay_in[3] = 40'(job_ff[5].a_y0);
      end
      if (job_ff[5].op == CMD_COBB) begin
         ex_in = 35'(41'(side_ff[5].cdx) - 41'(vbx_in[1]));
         ey_in = 35'(41'(side_ff[5].cdy) - 41'(vby_in[1]));
      end else begin
         ex_in = 35'(side_ff[5].cdx);
         ey_in = 35'(side_ff[5].cdy);
      end
   end

   // stage 8: projections on the four axes, circle distance test
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         pa_in[0][k] = 59'(vax7_ff[k]);
         pa_in[1][k] = 59'(vay7_ff[k]);
         pa_in[2][k] = 59'(ma_ff[k][0]) + 59'(ma_ff[k][1]);
         pa_in[3][k] = 59'(ma_ff[k][3]) - 59'(ma_ff[k][2]);
         pb_in[0][k] = 59'(vbx7_ff[k]);
         pb_in[1][k] = 59'(vby7_ff[k]);
         pb_in[2][k] = 59'(mb_ff[k][0]) + 59'(mb_ff[k][1]);
         pb_in[3][k] = 59'(mb_ff[k][3]) - 59'(mb_ff[k][2]);
      end
      chit_in = (71'(ex2_ff) + 71'(ey2_ff)) <= 71'(r2_ff);
   end

   // stage 9: interval ends per axis
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         amin_in[i] = pa_ff[i][0];
         amax_in[i] = pa_ff[i][0];
         bmin_in[i] = pb_ff[i][0];
         bmax_in[i] = pb_ff[i][0];
         for (int k = 1; k < 4; k++) begin
            if (pa_ff[i][k] < amin_in[i]) amin_in[i] = pa_ff[i][k];
            if (pa_ff[i][k] > amax_in[i]) amax_in[i] = pa_ff[i][k];
            if (pb_ff[i][k] < bmin_in[i]) bmin_in[i] = pb_ff[i][k];
            if (pb_ff[i][k] > bmax_in[i]) bmax_in[i] = pb_ff[i][k];
         end
      end
   end

   // stage 10: overlap on every axis, select by pair kind, no hit for a bad command
   always_comb begin
      ovl = 1'b1;
      for (int i = 0; i < 4; i++) begin
         if (!((bmin_ff[i] <= amax_ff[i]) && (amin_ff[i] <= bmax_ff[i]))) ovl = 1'b0;
      end
      case (job_ff[9].op)
         CMD_CC, CMD_CB, CMD_COBB: hit_in = chit9_ff;
         CMD_BB:                   hit_in = side_ff[9].bb;
         CMD_BOBB, CMD_OO:         hit_in = ovl;
         default:                  hit_in = 1'b0;
      endcase
      if (job_ff[9].bad) hit_in = 1'b0;
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NST-2:0], job_valid};
      end
   end

   // datapath registers, all moved together
   always_ff @(posedge clock) begin
      if (adv) begin
         job_ff[1]  <= job;
         side_ff[1] <= side_in;
         for (int k = 2; k <= 9; k++) begin
            job_ff[k]  <= job_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
         ux_ff  <= ux_in;
         uy_ff  <= uy_in;
         // stage 2: rotation products
         m1_ff  <= job_ff[1].t1.cos * ux_ff;
         m2_ff  <= job_ff[1].t1.sin * uy_ff;
         m3_ff  <= job_ff[1].t1.cos * uy_ff;
         m4_ff  <= job_ff[1].t1.sin * ux_ff;
         // stage 3: rounded rotation
         rx_ff  <= rnd_a(52'(m1_ff) + 52'(m2_ff));
         ry_ff  <= rnd_a(52'(m3_ff) - 52'(m4_ff));
         p_ff   <= p_in;
         q_ff   <= q_in;
         cx4_ff <= cx_in;
         cy4_ff <= cy_in;
         // stage 5: corner products
         pp1_ff <= job_ff[4].t2.cos * p_ff;
         pp2_ff <= job_ff[4].t2.sin * q_ff;
         pp3_ff <= job_ff[4].t2.sin * p_ff;
         pp4_ff <= job_ff[4].t2.cos * q_ff;
         cx5_ff <= cx4_ff;
         cy5_ff <= cy4_ff;
         vax_ff <= vax_in;
         vay_ff <= vay_in;
         vbx_ff <= vbx_in;
         vby_ff <= vby_in;
         ex_ff  <= ex_in;
         ey_ff  <= ey_in;
         // stage 7: axis products and squares
         for (int k = 0; k < 4; k++) begin
            ma_ff[k][0] <= job_ff[6].t2.cos * vax_ff[k];
            ma_ff[k][1] <= job_ff[6].t2.sin * vay_ff[k];
            ma_ff[k][2] <= job_ff[6].t2.sin * vax_ff[k];
            ma_ff[k][3] <= job_ff[6].t2.cos * vay_ff[k];
            mb_ff[k][0] <= job_ff[6].t2.cos * vbx_ff[k];
            mb_ff[k][1] <= job_ff[6].t2.sin * vby_ff[k];
            mb_ff[k][2] <= job_ff[6].t2.sin * vbx_ff[k];
            mb_ff[k][3] <= job_ff[6].t2.cos * vby_ff[k];
         end
         vax7_ff <= vax_ff;
         vay7_ff <= vay_ff;
         vbx7_ff <= vbx_ff;
         vby7_ff <= vby_ff;
         ex2_ff  <= ex_ff * ex_ff;
         ey2_ff  <= ey_ff * ey_ff;
         r2_ff   <= side_ff[6].rr * side_ff[6].rr;
         pa_ff    <= pa_in;
         pb_ff    <= pb_in;
         chit8_ff <= chit_in;
         amin_ff  <= amin_in;
         amax_ff  <= amax_in;
         bmin_ff  <= bmin_in;
         bmax_ff  <= bmax_in;
         chit9_ff <= chit8_ff;
         // result register
         hit_ff <= hit_in;
         bad_ff <= job_ff[9].bad;
      end
   end

endmodule

// ----- src/shape_pair_intersection_2d_core.sv -----
// throughput: one pair per cycle; the back pipeline of ten stages moves as one and
// stalls only while its result register holds an untaken result
// a four-entry queue lets the front keep taking pairs during such a stall until the queue is full
// reset: synchronous, active high; clears valid bits, queue pointers and queue fill count, nothing else
module shape_pair_intersection_2d_core import spi2d_pkg::*; #(
   parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
   parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // a_x0, a_y0, a_x1, a_y1, a_angle, b_x0, b_y0, b_x1, b_y1, b_angle
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // cmd
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // hit, zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // bad_cmd
   output logic [RSP_USER_W-1:0] rsp_tuser
);

   logic    f_valid, f_ready, q_valid, q_ready;
   job_type f_job, q_job;

   // classify and look up angles
   spi2d_front #(
      .COORD_WIDTH      (COORD_WIDTH),
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .job_valid  (f_valid),
      .job_ready  (f_ready),
      .job        (f_job)
   );

   // queue between front and back
   spi2d_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  (f_job),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_job)
   );

   // geometry pipeline
   spi2d_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (q_valid),
      .job_ready  (q_ready),
      .job        (q_job),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
